// File: rtl/positional_list_store_core_defines.svh
// Assertion macros shared by the list store checker.
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted during reset.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
package pls_pkg;

  // Widest cell index the chain supports (CAPACITY up to 1024).
  localparam int unsigned IDX_MAX_W = 10;

  typedef enum logic [2:0] {
    FN_ADD_HEAD = 3'd0,
    FN_ADD_END  = 3'd1,
    FN_INS_AT   = 3'd2,
    FN_DEL_HEAD = 3'd3,
    FN_DEL_END  = 3'd4,
    FN_DEL_AT   = 3'd5,
    FN_EDIT_AT  = 3'd6,
    FN_READ_AT  = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_op_t             op;
    logic [IDX_MAX_W-1:0] idx;
  } cell_ctrl_t;

endpackage

// File: rtl/pls_cell.sv
// One storage cell of the list chain: holds one element, shifts with its neighbors.
module pls_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                   clk,
  input  pls_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  wdata,
  input  logic [DATA_WIDTH-1:0]  left_data,
  input  logic [DATA_WIDTH-1:0]  right_data,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic [DATA_WIDTH-1:0]  rd_o
);

  localparam logic [pls_pkg::IDX_MAX_W-1:0] MY_IDX = pls_pkg::IDX_MAX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  sel;
  logic                  after;

  assign sel   = (ctrl.idx == MY_IDX);
  assign after = (MY_IDX > ctrl.idx);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      pls_pkg::CELL_INSERT: begin
        // take the left neighbor behind the slot, the new word at the slot
        if (after) begin
          data_nxt = left_data;
        end else if (sel) begin
          data_nxt = wdata;
        end
      end
      pls_pkg::CELL_DELETE: begin
        if (after || sel) begin
          data_nxt = right_data;
        end
      end
      pls_pkg::CELL_WRITE: begin
        if (sel) begin
          data_nxt = wdata;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = data_r & {DATA_WIDTH{sel}};

endmodule

// File: rtl/positional_list_store_core.sv
// Top level of the positional list store: decode, cell chain, count and result register.
//
//   channel | handshake             | fields
//   --------+-----------------------+------------------------------------------------
//   input   | in_valid / in_stall   | in_func, in_position, in_value
//   result  | out_valid / out_stall | out_status, out_element_count, out_read_value
//
// Each transfer is decoded at its accepting edge, where the chain inserts, deletes
// or writes at the slot, the cells behind it shifting; the result sits in the output
// register from the next cycle. One item per cycle while the result channel is not stalled.
// A new transfer is taken whenever that register is empty or being drained.
// A stall on the result channel holds the result and stalls the input.
// Reset (rst_n low, synchronous) clears the count and output valid, not the cells.
module positional_list_store_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_element_count,
  output logic [31:0] out_read_value
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;
  localparam int unsigned IW   = pls_pkg::IDX_MAX_W;

  logic                 accept;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  pls_pkg::status_t     out_status_r;
  pls_pkg::status_t     status;
  logic [6:0]           out_count_r;
  logic [31:0]          out_read_r;
  logic [31:0]          read_word;
  logic                 full;
  logic                 empty;
  logic                 in_range;
  logic                 do_read;
  pls_pkg::cell_ctrl_t  ctrl;
  pls_pkg::func_t       func;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [63:0]          wide_in;
  logic [63:0]          wide_rd;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  // Output register takes a new result whenever it is empty or draining.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign func     = pls_pkg::func_t'(in_func);
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign in_range = (in_position != 7'd0) && (CMPW'(in_position) <= CMPW'(count_r));

  // Mask the incoming word to the stored width.
  assign wide_in = 64'(in_value);
  assign wdata   = wide_in[DATA_WIDTH-1:0];

  // Decode the operation into one broadcast command for the chain.
  always_comb begin
    ctrl.op  = pls_pkg::CELL_HOLD;
    ctrl.idx = '0;
    status   = pls_pkg::ST_OK;
    do_read  = 1'b0;
    case (func)
      pls_pkg::FN_ADD_HEAD: begin
        if (full) begin
          status = pls_pkg::ST_FULL;
        end else begin
          ctrl.op = pls_pkg::CELL_INSERT;
        end
      end
      pls_pkg::FN_ADD_END: begin
        if (full) begin
          status = pls_pkg::ST_FULL;
        end else begin
          ctrl.op  = pls_pkg::CELL_INSERT;
          ctrl.idx = IW'(count_r);
        end
      end
      pls_pkg::FN_INS_AT: begin
        if (full) begin
          status = pls_pkg::ST_FULL;
        end else if (!in_range) begin
          status = pls_pkg::ST_RANGE;
        end else begin
          ctrl.op  = pls_pkg::CELL_INSERT;
          ctrl.idx = IW'(in_position) - IW'(1);
        end
      end
      pls_pkg::FN_DEL_HEAD: begin
        if (empty) begin
          status = pls_pkg::ST_EMPTY;
        end else begin
          ctrl.op = pls_pkg::CELL_DELETE;
        end
      end
      pls_pkg::FN_DEL_END: begin
        if (empty) begin
          status = pls_pkg::ST_EMPTY;
        end else begin
          ctrl.op  = pls_pkg::CELL_DELETE;
          ctrl.idx = IW'(count_r - CW'(1));
        end
      end
      pls_pkg::FN_DEL_AT, pls_pkg::FN_EDIT_AT, pls_pkg::FN_READ_AT: begin
        if (empty) begin
          status = pls_pkg::ST_EMPTY;
        end else if (!in_range) begin
          status = pls_pkg::ST_RANGE;
        end else begin
          ctrl.idx = IW'(in_position) - IW'(1);
          if (func == pls_pkg::FN_DEL_AT) begin
            ctrl.op = pls_pkg::CELL_DELETE;
          end else if (func == pls_pkg::FN_EDIT_AT) begin
            ctrl.op = pls_pkg::CELL_WRITE;
          end else begin
            do_read = 1'b1;
          end
        end
      end
      default: status = pls_pkg::ST_OK;
    endcase
    // Hold the chain when nothing is transferred.
    if (!accept) begin
      ctrl.op = pls_pkg::CELL_HOLD;
    end
  end

  // Cell chain: each cell sees its left and right neighbors (the new word left of the first, zero right of the last).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = wdata;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wdata      (wdata),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // Only the selected cell drives nonzero read data; merge them.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign wide_rd   = 64'(rd_or);
  assign read_word = do_read ? wide_rd[31:0] : 32'd0;

  // Advance the count on a successful insert or delete.
  always_comb begin
    count_nxt = count_r;
    case (ctrl.op)
      pls_pkg::CELL_INSERT: count_nxt = count_r + CW'(1);
      pls_pkg::CELL_DELETE: count_nxt = count_r - CW'(1);
      default:              count_nxt = count_r;
    endcase
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_count_r  <= 7'(count_nxt);
      out_read_r   <= read_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_read_value    = out_read_r;

endmodule

// File: rtl/pls_checker.sv
// Port-level assertions for the positional list store, bound to the top level.
`include "positional_list_store_core_defines.svh"

module pls_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [6:0]  out_element_count,
  input logic [31:0] out_read_value
);

  localparam logic [6:0] CAP7 = 7'(CAPACITY);

  `PLS_ASSERT_NOW(a_read_zero, out_valid && (out_status != pls_pkg::ST_OK), out_read_value == 32'd0, "read value nonzero on failed op")

  `PLS_ASSERT_NOW(a_full_count, out_valid && (out_status == pls_pkg::ST_FULL), out_element_count == CAP7, "full status with count below capacity")

  `PLS_ASSERT_NOW(a_empty_count, out_valid && (out_status == pls_pkg::ST_EMPTY), out_element_count == 7'd0, "empty status with nonzero count")

  `PLS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_element_count) && $stable(out_read_value), "stalled result changed")

endmodule

bind positional_list_store_core pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_element_count (out_element_count),
  .out_read_value    (out_read_value)
);
